[hw/rtl/socp_pkg.sv]
// Shared types for the shifted second-order cone projection.
// No dependencies; imported by the top level.
`default_nettype none

package socp_pkg;

    // Result classification of one projected vector.
    typedef enum logic [1:0] {
        REGION_INSIDE   = 2'd0,
        REGION_APEX     = 2'd1,
        REGION_BOUNDARY = 2'd2
    } t_region;

endpackage

`default_nettype wire

[hw/rtl/socp_isqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Standalone; carries a sideband tag alongside each radicand.
`default_nettype none

module socp_isqrt #(
    parameter int W     = 32,
    parameter int TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [2*W-1:0]   i_rad,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [W-1:0]          o_root,
    output logic [TAG_W-1:0]      o_tag
);

    logic             r_vld  [W];
    logic [2*W-1:0]   r_rad  [W];
    logic [W+1:0]     r_rem  [W];
    logic [W-1:0]     r_root [W];
    logic [TAG_W-1:0] r_tag  [W];

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic             p_vld;
        logic [2*W-1:0]   p_rad;
        logic [W+1:0]     p_rem;
        logic [W-1:0]     p_root;
        logic [TAG_W-1:0] p_tag;
        logic [W+1:0]     n_try;
        logic [W+1:0]     n_trial;
        logic [W+1:0]     n_diff;
        logic             n_ge;

        if (g == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_tag  = i_tag;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_rad  = r_rad[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_tag  = r_tag[g-1];
        end

        // Bring down two radicand bits and try appending a one to the root.
        assign n_try   = {p_rem[W-1:0], p_rad[2*W-1:2*W-2]};
        assign n_trial = {p_root, 2'b01};
        assign n_ge    = (n_try >= n_trial);
        assign n_diff  = n_try - n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
            r_rad[g]  <= {p_rad[2*W-3:0], 2'b00};
            r_rem[g]  <= n_ge ? n_diff : n_try;
            r_root[g] <= {p_root[W-2:0], n_ge};
            r_tag[g]  <= p_tag;
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_root  = r_root[W-1];
    assign o_tag   = r_tag[W-1];

endmodule

`default_nettype wire

[hw/rtl/socp_div.sv]
// Pipelined two-lane restoring divider with a shared divisor,
// one quotient bit per register stage. Standalone; carries a sideband tag.
`default_nettype none

module socp_div #(
    parameter int W     = 32,
    parameter int TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [2*W:0]     i_num_a,
    input  wire logic [2*W:0]     i_num_b,
    input  wire logic [W:0]       i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [W-1:0]          o_quot_a,
    output logic [W-1:0]          o_quot_b,
    output logic [TAG_W-1:0]      o_tag
);

    logic             r_vld   [W];
    logic [W:0]       r_den   [W];
    logic [W:0]       r_rem_a [W];
    logic [W:0]       r_rem_b [W];
    logic [W-1:0]     r_low_a [W];
    logic [W-1:0]     r_low_b [W];
    logic [W-1:0]     r_q_a   [W];
    logic [W-1:0]     r_q_b   [W];
    logic [TAG_W-1:0] r_tag   [W];

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic             p_vld;
        logic [W:0]       p_den;
        logic [W:0]       p_rem_a, p_rem_b;
        logic [W-1:0]     p_low_a, p_low_b;
        logic [W-1:0]     p_q_a, p_q_b;
        logic [TAG_W-1:0] p_tag;
        logic [W+1:0]     n_try_a, n_try_b, n_diff_a, n_diff_b, n_dext;
        logic             n_ge_a, n_ge_b;

        // The quotient fits in W bits, so the top numerator half is below the divisor.
        if (g == 0) begin : g_first
            assign p_vld   = i_valid;
            assign p_den   = i_den;
            assign p_rem_a = i_num_a[2*W:W];
            assign p_rem_b = i_num_b[2*W:W];
            assign p_low_a = i_num_a[W-1:0];
            assign p_low_b = i_num_b[W-1:0];
            assign p_q_a   = '0;
            assign p_q_b   = '0;
            assign p_tag   = i_tag;
        end else begin : g_next
            assign p_vld   = r_vld[g-1];
            assign p_den   = r_den[g-1];
            assign p_rem_a = r_rem_a[g-1];
            assign p_rem_b = r_rem_b[g-1];
            assign p_low_a = r_low_a[g-1];
            assign p_low_b = r_low_b[g-1];
            assign p_q_a   = r_q_a[g-1];
            assign p_q_b   = r_q_b[g-1];
            assign p_tag   = r_tag[g-1];
        end

        assign n_dext   = {1'b0, p_den};
        assign n_try_a  = {p_rem_a, p_low_a[W-1]};
        assign n_try_b  = {p_rem_b, p_low_b[W-1]};
        assign n_ge_a   = (n_try_a >= n_dext);
        assign n_ge_b   = (n_try_b >= n_dext);
        assign n_diff_a = n_try_a - n_dext;
        assign n_diff_b = n_try_b - n_dext;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
            r_den[g]   <= p_den;
            r_rem_a[g] <= n_ge_a ? n_diff_a[W:0] : n_try_a[W:0];
            r_rem_b[g] <= n_ge_b ? n_diff_b[W:0] : n_try_b[W:0];
            r_low_a[g] <= {p_low_a[W-2:0], 1'b0};
            r_low_b[g] <= {p_low_b[W-2:0], 1'b0};
            r_q_a[g]   <= {p_q_a[W-2:0], n_ge_a};
            r_q_b[g]   <= {p_q_b[W-2:0], n_ge_b};
            r_tag[g]   <= p_tag;
        end
    end

    assign o_valid  = r_vld[W-1];
    assign o_quot_a = r_q_a[W-1];
    assign o_quot_b = r_q_b[W-1];
    assign o_tag    = r_tag[W-1];

endmodule

`default_nettype wire

[hw/rtl/soc3_shifted_projection.sv]
// Top level of the shifted 3-D second-order cone projection pipeline.
// Depends on socp_pkg, socp_isqrt and socp_div.
//
// The block takes one request per clock cycle and returns each result marked by a
// one-cycle o_valid strobe. The pipeline depth is set by the square root and the
// divider, each of which resolves one result bit per register stage (DATA_WIDTH
// stages apiece), plus seven stages for input capture, squaring, summing,
// classification, multiplication, numerator forming and output saturation. The
// receiver cannot stall, so busy is low at all times except while reset is asserted.
`default_nettype none

module soc3_shifted_projection
    import socp_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [DATA_WIDTH-1:0] i_axial_in,
    input  wire logic [DATA_WIDTH-1:0] i_radial_a_in,
    input  wire logic [DATA_WIDTH-1:0] i_radial_b_in,
    input  wire logic                  i_cone_negative,
    input  wire logic [DATA_WIDTH-1:0] i_shift,
    output logic                       o_valid,
    output logic [DATA_WIDTH-1:0]      o_axial_out,
    output logic [DATA_WIDTH-1:0]      o_radial_a_out,
    output logic [DATA_WIDTH-1:0]      o_radial_b_out,
    output logic [1:0]                 o_region
);

    localparam int W      = DATA_WIDTH;
    localparam int PW     = 2 * W + 1;
    localparam int STAG_W = 4 * W + 1;
    localparam int DTAG_W = 3 * W + 2;
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // Clamp a value two bits wider than the data path to the data range.
    function automatic logic [W-1:0] sat_data(input logic [W+1:0] v);
        logic fits;
        fits = (v[W+1] == v[W]) && (v[W] == v[W-1]);
        if (fits) begin
            sat_data = v[W-1:0];
        end else if (v[W+1]) begin
            sat_data = SAT_MIN;
        end else begin
            sat_data = SAT_MAX;
        end
    endfunction

    // Give the rounded magnitude the original sign; positives past range saturate.
    function automatic logic [W-1:0] signed_mag(input logic neg, input logic [W-1:0] q);
        if (neg) begin
            signed_mag = ~q + 1'b1;
        end else if (q[W-1]) begin
            signed_mag = SAT_MAX;
        end else begin
            signed_mag = q;
        end
    endfunction

    // Requests are only lost while reset clears the pipeline.
    assign busy = ~i_rst_n;

    // Stage 0: capture the request and take the radial magnitudes.
    logic         r0_valid;
    logic [W-1:0] r0_x0, r0_x1, r0_x2, r0_d, r0_a1, r0_a2;
    logic         r0_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start & ~busy;
        end
        r0_x0  <= i_axial_in;
        r0_x1  <= i_radial_a_in;
        r0_x2  <= i_radial_b_in;
        r0_d   <= i_shift;
        r0_neg <= i_cone_negative;
        r0_a1  <= i_radial_a_in[W-1] ? (~i_radial_a_in + 1'b1) : i_radial_a_in;
        r0_a2  <= i_radial_b_in[W-1] ? (~i_radial_b_in + 1'b1) : i_radial_b_in;
    end

    // Stage 1: square each radial magnitude.
    logic              r1_valid;
    logic [2*W-1:0]    r1_sq_a, r1_sq_b;
    logic [STAG_W-1:0] r1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
        r1_sq_a <= (2*W)'(r0_a1) * (2*W)'(r0_a1);
        r1_sq_b <= (2*W)'(r0_a2) * (2*W)'(r0_a2);
        r1_tag  <= {r0_neg, r0_d, r0_x2, r0_x1, r0_x0};
    end

    // Stage 2: the sum of squares cannot exceed 2^(2W-1), so 2W bits hold it.
    logic              r2_valid;
    logic [2*W-1:0]    r2_sum;
    logic [STAG_W-1:0] r2_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_sum <= r1_sq_a + r1_sq_b;
        r2_tag <= r1_tag;
    end

    logic              q_valid;
    logic [W-1:0]      q_norm;
    logic [STAG_W-1:0] q_tag;

    socp_isqrt #(
        .W     (W),
        .TAG_W (STAG_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_rad   (r2_sum),
        .i_tag   (r2_tag),
        .o_valid (q_valid),
        .o_root  (q_norm),
        .o_tag   (q_tag)
    );

    // Classification: c = dir*(x0-shift) against the radial norm n.
    logic [W-1:0] q_x0, q_x1, q_x2, q_d;
    logic         q_neg;
    logic [W:0]   n_diff, n_c, n_m, n_half;
    logic [W+1:0] n_cx, n_nx, n_mx, n_hsum, n_axs;
    logic         n_inside, n_apex;
    t_region      n_region;
    logic [W-1:0] n_axial;

    assign {q_neg, q_d, q_x2, q_x1, q_x0} = q_tag;

    always_comb begin
        n_diff   = {q_x0[W-1], q_x0} - {q_d[W-1], q_d};
        n_c      = q_neg ? (~n_diff + 1'b1) : n_diff;
        n_cx     = {n_c[W], n_c};
        n_nx     = {2'b00, q_norm};
        n_inside = ($signed(n_nx) <= $signed(n_cx));
        n_apex   = ($signed(n_nx) <= $signed(~n_cx + 1'b1));
        n_mx     = n_cx + n_nx;
        n_m      = n_mx[W:0];
        // Half of m, rounded half up, added to the apex along the cone direction.
        n_hsum   = {1'b0, n_m} + (W+2)'(1);
        n_half   = n_hsum[W+1:1];
        n_axs    = q_neg ? ({{2{q_d[W-1]}}, q_d} - {1'b0, n_half})
                         : ({{2{q_d[W-1]}}, q_d} + {1'b0, n_half});
        if (n_inside) begin
            n_region = REGION_INSIDE;
            n_axial  = q_x0;
        end else if (n_apex) begin
            n_region = REGION_APEX;
            n_axial  = q_d;
        end else begin
            n_region = REGION_BOUNDARY;
            n_axial  = sat_data(n_axs);
        end
    end

    // Stage P1: classification results and the scale factor m.
    logic         r3_valid;
    t_region      r3_region;
    logic [W-1:0] r3_axial, r3_x1, r3_x2, r3_a1, r3_a2, r3_n;
    logic [W:0]   r3_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= q_valid;
        end
        r3_region <= n_region;
        r3_axial  <= n_axial;
        r3_x1     <= q_x1;
        r3_x2     <= q_x2;
        r3_a1     <= q_x1[W-1] ? (~q_x1 + 1'b1) : q_x1;
        r3_a2     <= q_x2[W-1] ? (~q_x2 + 1'b1) : q_x2;
        r3_n      <= q_norm;
        r3_m      <= n_m;
    end

    // Stage P2: |xi| * m for both radial components.
    logic         r4_valid;
    t_region      r4_region;
    logic [W-1:0] r4_axial, r4_x1, r4_x2, r4_n;
    logic [PW-1:0] r4_pa, r4_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_region <= r3_region;
        r4_axial  <= r3_axial;
        r4_x1     <= r3_x1;
        r4_x2     <= r3_x2;
        r4_n      <= r3_n;
        r4_pa     <= PW'(r3_a1) * PW'(r3_m);
        r4_pb     <= PW'(r3_a2) * PW'(r3_m);
    end

    // Stage P3: add n for rounding and form the divisor 2n.
    logic              r5_valid;
    logic [PW-1:0]     r5_num_a, r5_num_b;
    logic [W:0]        r5_den;
    logic [DTAG_W-1:0] r5_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_num_a <= r4_pa + PW'(r4_n);
        r5_num_b <= r4_pb + PW'(r4_n);
        r5_den   <= {r4_n, 1'b0};
        r5_tag   <= {r4_region, r4_axial, r4_x2, r4_x1};
    end

    logic              d_valid;
    logic [W-1:0]      d_qa, d_qb;
    logic [DTAG_W-1:0] d_tag;

    socp_div #(
        .W     (W),
        .TAG_W (DTAG_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r5_valid),
        .i_num_a  (r5_num_a),
        .i_num_b  (r5_num_b),
        .i_den    (r5_den),
        .i_tag    (r5_tag),
        .o_valid  (d_valid),
        .o_quot_a (d_qa),
        .o_quot_b (d_qb),
        .o_tag    (d_tag)
    );

    // Output stage: pick the radial results by region and register them.
    logic [1:0]   d_region_bits;
    t_region      d_region;
    logic [W-1:0] d_axial, d_x1, d_x2, n_ra, n_rb;

    assign {d_region_bits, d_axial, d_x2, d_x1} = d_tag;
    assign d_region = t_region'(d_region_bits);

    always_comb begin
        case (d_region)
            REGION_INSIDE: begin
                n_ra = d_x1;
                n_rb = d_x2;
            end
            REGION_APEX: begin
                n_ra = '0;
                n_rb = '0;
            end
            default: begin
                n_ra = signed_mag(d_x1[W-1], d_qa);
                n_rb = signed_mag(d_x2[W-1], d_qb);
            end
        endcase
    end

    logic         r_out_valid;
    logic [W-1:0] r_out_axial, r_out_ra, r_out_rb;
    logic [1:0]   r_out_region;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= d_valid;
        end
        r_out_axial  <= d_axial;
        r_out_ra     <= n_ra;
        r_out_rb     <= n_rb;
        r_out_region <= d_region_bits;
    end

    assign o_valid        = r_out_valid;
    assign o_axial_out    = r_out_axial;
    assign o_radial_a_out = r_out_ra;
    assign o_radial_b_out = r_out_rb;
    assign o_region       = r_out_region;

`ifndef SYNTHESIS
    localparam int LAT = 2 * W + 7;

    // Every accepted request comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result strobe missing after fixed latency");

    // A vector inside the cone leaves unchanged.
    a_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region == REGION_INSIDE) |->
            (o_axial_out == $past(i_axial_in, LAT)) &&
            (o_radial_a_out == $past(i_radial_a_in, LAT)) &&
            (o_radial_b_out == $past(i_radial_b_in, LAT)))
        else $error("inside result differs from its request");

    // A vector collapsed to the apex gives the shift and zero radials.
    a_apex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region == REGION_APEX) |->
            (o_axial_out == $past(i_shift, LAT)) &&
            (o_radial_a_out == '0) && (o_radial_b_out == '0))
        else $error("apex result is not the cone apex");
`endif

endmodule

`default_nettype wire

[tb/soc3_shifted_projection_chk.sv]
// Checker for the cone projection block: watches accepted requests and result strobes,
// predicts each result in exact wide integer arithmetic and compares field by field.
// Depends on socp_pkg for the region codes.
`default_nettype none

module soc3_shifted_projection_chk
    import socp_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [DATA_WIDTH-1:0] i_axial,
    input  wire logic [DATA_WIDTH-1:0] i_radial_a,
    input  wire logic [DATA_WIDTH-1:0] i_radial_b,
    input  wire logic                  i_cone_negative,
    input  wire logic [DATA_WIDTH-1:0] i_shift,
    input  wire logic                  i_valid,
    input  wire logic [DATA_WIDTH-1:0] i_axial_out,
    input  wire logic [DATA_WIDTH-1:0] i_radial_a_out,
    input  wire logic [DATA_WIDTH-1:0] i_radial_b_out,
    input  wire logic [1:0]            i_region,
    output int                         o_errors,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] axial;
        logic [DATA_WIDTH-1:0] radial_a;
        logic [DATA_WIDTH-1:0] radial_b;
        t_region               region;
    } t_projection;

    t_projection projections_due[$];

    function automatic logic [DATA_WIDTH-1:0] clamp(input logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[DATA_WIDTH-1:0];
    endfunction

    // Bitwise integer square root, floor.
    function automatic logic [127:0] root_floor(input logic [127:0] s);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    // x*m/(2n), rounded half away from zero.
    function automatic logic signed [127:0] scale_radial(input logic signed [127:0] x,
                                                         input logic [127:0] m,
                                                         input logic [127:0] n);
        logic [127:0] ax;
        logic [127:0] q;
        ax = (x < 0) ? -x : x;
        q = (ax * m + n) / (2 * n);
        return (x < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_projection project(input logic [DATA_WIDTH-1:0] a,
                                            input logic [DATA_WIDTH-1:0] r1,
                                            input logic [DATA_WIDTH-1:0] r2,
                                            input logic neg,
                                            input logic [DATA_WIDTH-1:0] d_in);
        logic signed [127:0] x0;
        logic signed [127:0] x1;
        logic signed [127:0] x2;
        logic signed [127:0] d;
        logic signed [127:0] c;
        logic signed [127:0] n;
        logic signed [127:0] m;
        logic signed [127:0] half;
        t_projection p;
        x0 = $signed(a);
        x1 = $signed(r1);
        x2 = $signed(r2);
        d  = $signed(d_in);
        n  = $signed(root_floor(x1 * x1 + x2 * x2));
        c  = neg ? d - x0 : x0 - d;
        if (n <= c) begin
            p = '{a, r1, r2, REGION_INSIDE};
        end else if (n <= -c) begin
            p = '{d_in, '0, '0, REGION_APEX};
        end else begin
            m = c + n;
            half = (m + 1) >>> 1;
            p.axial    = clamp(neg ? d - half : d + half);
            p.radial_a = clamp(scale_radial(x1, m, n));
            p.radial_b = clamp(scale_radial(x2, m, n));
            p.region   = REGION_BOUNDARY;
        end
        return p;
    endfunction

    assign o_pending = projections_due.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_projection want;
        int bad;
        bad = 0;
        if (i_rst_n && i_start && !i_busy) begin
            projections_due.push_back(project(i_axial, i_radial_a, i_radial_b,
                                              i_cone_negative, i_shift));
        end
        if (i_rst_n && i_valid) begin
            if (projections_due.size() == 0) begin
                $error("result strobe with no request outstanding");
                bad++;
            end else begin
                want = projections_due.pop_front();
                if (i_axial_out !== want.axial) begin
                    $error("axial_out expected %h got %h", want.axial, i_axial_out);
                    bad++;
                end
                if (i_radial_a_out !== want.radial_a) begin
                    $error("radial_a_out expected %h got %h", want.radial_a, i_radial_a_out);
                    bad++;
                end
                if (i_radial_b_out !== want.radial_b) begin
                    $error("radial_b_out expected %h got %h", want.radial_b, i_radial_b_out);
                    bad++;
                end
                if (i_region !== want.region) begin
                    $error("region expected %0d got %0d", want.region, i_region);
                    bad++;
                end
            end
        end
        if (bad != 0) begin
            o_errors <= o_errors + bad;
        end
    end

endmodule

`default_nettype wire

[tb/soc3_shifted_projection_tb.sv]
// Top of the cone projection testbench: makes requests, idles in bursts and gives the verdict.
// Depends on soc3_shifted_projection, soc3_shifted_projection_chk and socp_pkg.
`default_nettype none

module soc3_shifted_projection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    // Pipeline depth from the head of the block.
    localparam int LATENCY = 2 * W + 7;
    localparam int CYCLE_LIMIT = 200000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic [W-1:0] axial = '0;
    logic [W-1:0] radial_a = '0;
    logic [W-1:0] radial_b = '0;
    logic         cone_neg = 1'b0;
    logic [W-1:0] shift = '0;
    logic         busy;
    logic         valid;
    logic [W-1:0] axial_out;
    logic [W-1:0] radial_a_out;
    logic [W-1:0] radial_b_out;
    logic [1:0]   region;
    int           errors;
    int           pending;
    int           cycles = 0;

    always #5 clk = ~clk;

    soc3_shifted_projection #(.DATA_WIDTH(W)) uut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_axial_in(axial), .i_radial_a_in(radial_a), .i_radial_b_in(radial_b),
        .i_cone_negative(cone_neg), .i_shift(shift),
        .o_valid(valid), .o_axial_out(axial_out), .o_radial_a_out(radial_a_out),
        .o_radial_b_out(radial_b_out), .o_region(region)
    );

    soc3_shifted_projection_chk #(.DATA_WIDTH(W)) chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_axial(axial), .i_radial_a(radial_a), .i_radial_b(radial_b),
        .i_cone_negative(cone_neg), .i_shift(shift),
        .i_valid(valid), .i_axial_out(axial_out), .i_radial_a_out(radial_a_out),
        .i_radial_b_out(radial_b_out), .i_region(region),
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog: a hung pipeline or a lost strobe ends here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("soc3_shifted_projection test failed");
            $finish;
        end
    end

    // Mostly small magnitudes so that all three regions are common, sometimes full range
    // so that saturation and the extremes of the square root are reached.
    function automatic logic [W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(W - 1){1'b0}}} |
                            ($urandom_range(0, 1) ? {1'b0, {(W - 1){1'b1}}} : '0);
            2, 3:    return W'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
            4:       return W'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            default: return W'($signed($urandom_range(0, 32'h00A0_0000)) - 32'sh0050_0000);
        endcase
    endfunction

    // Holds one request on the ports until the block takes it.
    // The caller lowers start, so back-to-back requests keep it high.
    task automatic send_request(input logic [W-1:0] a, input logic [W-1:0] r1,
                                input logic [W-1:0] r2, input logic neg,
                                input logic [W-1:0] d);
        axial    <= a;
        radial_a <= r1;
        radial_b <= r2;
        cone_neg <= neg;
        shift    <= d;
        start    <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    localparam logic [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};
    localparam logic [W-1:0] ONE  = W'(32'h0001_0000);

    initial begin
        int burst;
        int wait_cycles;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: inside, apex and boundary for both directions, zero radius,
        // extreme inputs that saturate, and a one-LSB radius.
        send_request(ONE * 5, ONE * 3, ONE * 4, 1'b0, '0);
        send_request(-(ONE * 5), ONE * 3, ONE * 4, 1'b1, '0);
        send_request(-(ONE * 6), ONE * 3, ONE * 4, 1'b0, '0);
        send_request(ONE * 6, ONE * 3, ONE * 4, 1'b1, '0);
        send_request(ONE, ONE * 3, ONE * 4, 1'b0, ONE);
        send_request(ONE, ONE * 3, -(ONE * 4), 1'b1, -ONE);
        send_request('0, '0, '0, 1'b0, '0);
        send_request('0, '0, '0, 1'b1, '0);
        send_request(MINV, '0, '0, 1'b0, MAXV);
        send_request(MAXV, '0, '0, 1'b1, MINV);
        send_request(MINV, MINV, MINV, 1'b0, MAXV);
        send_request(MAXV, MAXV, MAXV, 1'b1, MINV);
        send_request(MAXV, MINV, MAXV, 1'b0, MAXV);
        send_request(MINV, MAXV, MINV, 1'b1, MINV);
        send_request(MAXV, MAXV, MINV, 1'b0, MINV);
        send_request(MINV, MINV, MAXV, 1'b1, MAXV);
        send_request('0, W'(1), '0, 1'b0, '0);
        send_request('0, '1, W'(1), 1'b1, '0);
        send_request('1, '1, '1, 1'b0, '1);
        send_request(MAXV, '0, '0, 1'b0, MAXV);
        idle_for(1);

        // Pause until the pipeline has drained completely.
        while (pending != 0) @(negedge clk);

        // Random requests in bursts, with gaps of varied length and long gap-free runs.
        for (int i = 0; i < 1700; i += burst) begin
            burst = $urandom_range(1, 60);
            for (int k = 0; k < burst; k++) begin
                send_request(pick_value(), pick_value(), pick_value(),
                             1'($urandom_range(0, 1)), pick_value());
            end
            case ($urandom_range(0, 5))
                0:       idle_for($urandom_range(LATENCY - 5, LATENCY + 5));
                1, 2:    idle_for($urandom_range(1, 3));
                3:       idle_for($urandom_range(4, 40));
                default: ;
            endcase
        end
        idle_for(1);

        while (pending != 0) @(negedge clk);
        wait_cycles = 0;
        while (wait_cycles < LATENCY + 10) begin
            @(negedge clk);
            wait_cycles++;
        end

        if (errors == 0) begin
            $display("soc3_shifted_projection test passed");
        end else begin
            $display("soc3_shifted_projection test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[soc3_shifted_projection.f]
hw/rtl/socp_pkg.sv
hw/rtl/socp_isqrt.sv
hw/rtl/socp_div.sv
hw/rtl/soc3_shifted_projection.sv
tb/soc3_shifted_projection_chk.sv
tb/soc3_shifted_projection_tb.sv
